/* sv/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the RPN evaluator
// Character codes, status codes, decode helpers and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned WORD_W          = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADCHAR   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_NOTONE    = 3'd3,
    ST_DIVZERO   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_DIGIT,
    CLS_OP,
    CLS_BAD
  } cls_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch_in;   // capture the incoming word
    logic    push;       // push the digit value
    logic    rd_nos;     // read the entry under the top
    logic    alu_ld;     // load add/sub/mul result
    logic    div_start;  // launch the divider
    logic    div_ld;     // load the quotient
    logic    wb;         // replace top with result, pop one
    logic    set_err;    // record an error code
    status_t err_code;
    logic    load_out;   // form the result word and clear the stack
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    cls_t cls;
    logic is_div;
    logic last;
    logic err_set;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic div_done;
  } sts_t;

  function automatic cls_t classify(input logic [7:0] ch);
    cls_t cls;
    unique case (ch) inside
      CH_SPACE:                             cls = CLS_SPACE;
      [CH_ZERO:CH_NINE]:                    cls = CLS_DIGIT;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: cls = CLS_OP;
      default:                              cls = CLS_BAD;
    endcase
    return cls;
  endfunction

  function automatic op_t op_of(input logic [7:0] ch);
    op_t op;
    unique case (ch)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      default:  op = OP_DIV;
    endcase
    return op;
  endfunction

endpackage

/* sv/rpn_if.sv */
// ----------------------------------------------------------------------------
// rpn_if: valid/ready channels of the RPN evaluator
// Character channel in, result channel out.
// ----------------------------------------------------------------------------
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* sv/rpn_div.sv */
// ----------------------------------------------------------------------------
// rpn_div: signed 32-bit divider, truncating toward zero
// Restoring divide on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rpn_pkg::WORD_W-1:0]        dividend,
  input  logic [rpn_pkg::WORD_W-1:0]        divisor,
  output logic                              done,
  output logic [rpn_pkg::WORD_W-1:0]        quotient
);
  import rpn_pkg::*;

  localparam int unsigned CW = $clog2(WORD_W);

  logic              run_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dvs_r;
  logic              neg_r;
  logic [WORD_W:0]   trial;

  assign trial = {rem_r, quo_r[WORD_W-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(WORD_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      dvs_r <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      rem_r <= '0;
      neg_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (!trial[WORD_W]) begin
        rem_r <= trial[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (WORD_W'(0) - quo_r) : quo_r;

endmodule

/* sv/rpn_dp.sv */
// ----------------------------------------------------------------------------
// rpn_dp: datapath of the RPN evaluator
// Top of stack in a register, the rest in a one-read one-write memory,
// add/sub/mul unit, divider, depth and error registers, result register.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpn_pkg::cmd_t                     cmd,
  output rpn_pkg::sts_t                     sts,
  input  logic [7:0]                        in_ch,
  input  logic                              in_last,
  output logic signed [rpn_pkg::WORD_W-1:0] out_value,
  output logic [2:0]                        out_status
);
  import rpn_pkg::*;

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  logic [7:0]        ch_r;
  logic              last_r;
  logic [WORD_W-1:0] tos_r;
  logic [WORD_W-1:0] rd_r;
  logic [WORD_W-1:0] res_r;
  logic [WORD_W-1:0] alu;
  logic [DW-1:0]     depth_r, depth_nxt;
  status_t           err_r, err_nxt;
  logic [WORD_W-1:0] value_r;
  status_t           status_r;
  logic [DW-1:0]     wr_idx;
  logic [DW-1:0]     rd_idx;
  op_t               op;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  assign op     = op_of(ch_r);
  assign wr_idx = depth_r - DW'(1);
  assign rd_idx = depth_r - DW'(2);

  // input capture and stack memory
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
    if (cmd.push) begin
      tos_r <= {{(WORD_W - 8){1'b0}}, 8'(ch_r - CH_ZERO)};
      if (depth_r != '0) begin
        mem[wr_idx[AW-1:0]] <= tos_r;
      end
    end else if (cmd.wb) begin
      tos_r <= res_r;
    end
    if (cmd.rd_nos) begin
      rd_r <= mem[rd_idx[AW-1:0]];
    end
  end

  // left operand is the entry below the top
  always_comb begin
    case (op)
      OP_ADD:  alu = rd_r + tos_r;
      OP_SUB:  alu = rd_r - tos_r;
      OP_MUL:  alu = WORD_W'(rd_r * tos_r);
      default: alu = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.alu_ld) begin
      res_r <= alu;
    end else if (cmd.div_ld) begin
      res_r <= div_q;
    end
  end

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    depth_nxt = depth_r;
    err_nxt   = err_r;
    if (cmd.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (cmd.wb) begin
      depth_nxt = depth_r - DW'(1);
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end
    if (cmd.load_out) begin
      depth_nxt = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ST_OK;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  // result word: first error wins, else exactly one value must remain
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (err_r != ST_OK) begin
        status_r <= err_r;
        value_r  <= '0;
      end else if (depth_r == DW'(1)) begin
        status_r <= ST_OK;
        value_r  <= tos_r;
      end else begin
        status_r <= ST_NOTONE;
        value_r  <= '0;
      end
    end
  end

  assign out_value  = value_r;
  assign out_status = status_r;

  assign sts.cls      = classify(ch_r);
  assign sts.is_div   = (op == OP_DIV);
  assign sts.last     = last_r;
  assign sts.err_set  = (err_r != ST_OK);
  assign sts.full     = (depth_r == DW'(STACK_DEPTH));
  assign sts.lt2      = (depth_r < DW'(2));
  assign sts.rhs_zero = (tos_r == '0);
  assign sts.div_done = div_done;

endmodule

/* sv/rpn_ctrl.sv */
// ----------------------------------------------------------------------------
// rpn_ctrl: controller of the RPN evaluator
// Sequences one character word through decode, operand read, arithmetic
// and write-back, and owns the result word's valid flag.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rpn_pkg::cmd_t  cmd,
  input  rpn_pkg::sts_t  sts
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DIV,
    S_WB,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  state_t done_state;

  assign in_ready   = (state_r == S_IDLE);
  assign done_state = sts.last ? S_FIN : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.latch_in = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = done_state;
        if (!sts.err_set) begin
          unique case (sts.cls)
            CLS_SPACE: ;
            CLS_DIGIT: begin
              if (sts.full) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
            end
            CLS_OP: begin
              if (sts.lt2) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_UNDERFLOW;
              end else begin
                cmd.rd_nos = 1'b1;
                state_nxt  = S_READ;
              end
            end
            default: begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_BADCHAR;
            end
          endcase
        end
      end
      S_READ: begin
        if (!sts.is_div) begin
          cmd.alu_ld = 1'b1;
          state_nxt  = S_WB;
        end else if (sts.rhs_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZERO;
          state_nxt    = done_state;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_ld = 1'b1;
          state_nxt  = S_WB;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = done_state;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/rpn_digit_stack_evaluator.sv */
// Each word is latched in idle and decoded in exec; a space, digit or bad
// character ends there, + - * go on through read and write-back, / through
// read, divide (one quotient bit per cycle) and write-back. A word marked
// last forms the result in the output register when free; one word at a time.
// Reset (rst_n low, synchronous): controller, stack depth, error code and
// output valid are cleared; stack contents are not touched.
// ----------------------------------------------------------------------------
// rpn_digit_stack_evaluator: reverse Polish calculator on single digits
// Takes one expression character per word and returns value and status on
// the word marked last.
// ----------------------------------------------------------------------------
module rpn_digit_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rpn_in_if.sink      in_chan,
  rpn_out_if.source   out_chan
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: decides per character what the datapath does. Words are
  // taken only in its idle state; a finished result waits in the output
  // register while the next expression already streams in.
  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: top of stack lives in a register, deeper entries in memory,
  // so an operator needs just one memory read for its left operand.
  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_ch      (in_chan.ch),
    .in_last    (in_chan.last),
    .out_value  (out_chan.value),
    .out_status (out_chan.status)
  );

`ifndef NO_ASSERTIONS
  // a result word is only formed for the character marked last
  a_out_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.last)
    else $error("result formed for a word not marked last");

  // never push beyond capacity
  a_no_overpush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push on a full stack");

  // operand read only with two values present
  a_read_two: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_nos |-> !sts.lt2)
    else $error("operand read with fewer than two values");

  // the first error is never overwritten
  a_first_err: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_err |-> !sts.err_set)
    else $error("sticky error overwritten");
`endif

endmodule
